// ===== sv/rasst_pkg.sv =====
// Shared types and constants of the range assign/add/sum tree unit.
// No dependencies; every other file but rasst_ram refers to it by scoped names.
`default_nettype none
package rasst_pkg;

  localparam int SUM_W = 64;
  localparam int TAG_W = 2 * SUM_W + 1;   // {assign flag, assign value, pending add}
  localparam int CFG_W = 11;
  localparam int RIDX_W = 10;             // width of the range index fields
  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam logic [CFG_W-1:0] USED_SIZE_RST = 11'd1024;

  localparam logic [1:0] ACT_ASSIGN = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  typedef struct packed {
    logic clr;         // write zero records
    logic wr_sum;      // write sum store
    logic wr_tag;      // write tag store
    logic pull;        // sum write = left + right child sums
    logic par_wr;      // tag write = parent tags with add and flag cleared
    logic ld_item;     // capture operand, clear accumulator
    logic ld_rec;      // capture node record from the stores
    logic ld_par;      // capture parent tags from the tag store
    logic ld_src_item; // tag source from the item
    logic ld_src_par;  // tag source from the parent
    logic item_asg;
    logic item_add;
    logic mul_val;     // product = source assign value * length
    logic mul_add;     // product = source add * length
    logic app_asg;
    logic app_add;
    logic acc_add;     // accumulator += node sum
    logic ld_left;     // hold left child sum
    logic ld_out;
    logic out_bad;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== sv/range_assign_add_sum_tree_unit.sv =====
// Top level of the lazy segment tree unit (range assign, range add, range sum).
// Uses rasst_pkg, rasst_ctrl, rasst_dp (and rasst_ram through rasst_dp).
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------------
//   in      | in_valid / in_stall        | action, range_low, range_high, operand_value
//   out     | out_valid / out_stall      | range_sum, status
//   cfg     | cfg_wr_en (no wait)        | cfg_wr_data -> used_size
//
// One item is worked at a time; the walk is sequenced node by node over one
// sum store and one tag store, each with one read and one write per cycle.
// A bad item goes from acceptance straight to the result load. A good item is
// accepted, internal nodes on its path are pushed down, covered nodes are updated
// (or summed on a query), updated parents pull their sums up, and the result is loaded.
// After reset a clearing pass over all 4*MAX_ELEMENTS nodes zeroes both stores;
// in_stall stays high during it. Configuration writes are taken at any time.
// The finished result sits in an output register, so a stalled result does
// not keep the next item from being accepted.
`default_nettype none
module range_assign_add_sum_tree_unit #(
  parameter int MAX_ELEMENTS = rasst_pkg::DEF_MAX_ELEMENTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      action,
  input  wire logic [rasst_pkg::RIDX_W-1:0]    range_low,
  input  wire logic [rasst_pkg::RIDX_W-1:0]    range_high,
  input  wire logic [rasst_pkg::SUM_W-1:0]     operand_value,
  input  wire logic                            cfg_wr_en,
  input  wire logic [rasst_pkg::CFG_W-1:0]     cfg_wr_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [rasst_pkg::SUM_W-1:0]     range_sum,
  output logic                                 status
);

  localparam int IW  = $clog2(MAX_ELEMENTS);
  localparam int LW  = IW + 1;
  localparam int NAW = IW + 2;

  rasst_pkg::dp_cmd_t cmd;
  logic [NAW-1:0]     addr;
  logic [LW-1:0]      len;

  // Sequencer: clearing sweep, descent stack, per-node step order.
  rasst_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .range_low(range_low), .range_high(range_high),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .addr(addr), .len(len)
  );

  // Stores, tag arithmetic (one multiplier, registered), accumulator, result.
  rasst_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk(clk), .operand_value(operand_value),
    .cmd(cmd), .addr(addr), .len(len),
    .range_sum(range_sum), .status(status)
  );

endmodule
`default_nettype wire

// ===== sv/rasst_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none
module rasst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/rasst_dp.sv =====
// Datapath: node sum and tag stores, tag arithmetic, accumulator, result register.
// Uses rasst_pkg and rasst_ram.
`default_nettype none
module rasst_dp #(
  parameter int MAX_ELEMENTS = rasst_pkg::DEF_MAX_ELEMENTS,
  localparam int IW  = $clog2(MAX_ELEMENTS),
  localparam int LW  = IW + 1,
  localparam int NAW = IW + 2
) (
  input  wire logic                           clk,
  input  wire logic [rasst_pkg::SUM_W-1:0]    operand_value,
  input  wire rasst_pkg::dp_cmd_t             cmd,
  input  wire logic [NAW-1:0]                 addr,
  input  wire logic [LW-1:0]                  len,
  output logic      [rasst_pkg::SUM_W-1:0]    range_sum,
  output logic                                status
);

  localparam int SW = rasst_pkg::SUM_W;
  localparam int NODES = 4 * MAX_ELEMENTS;

  logic [SW-1:0] operand, acc, left_sum, prod;
  logic [SW-1:0] rec_sum, rec_add, rec_av;
  logic          rec_flag;
  logic [SW-1:0] par_add, par_av;
  logic          par_flag;
  logic [SW-1:0] src_val, src_add;
  logic          src_flag;
  logic [LW-1:0] len_r;

  logic [SW-1:0]               sum_rd, sum_wd;
  logic [rasst_pkg::TAG_W-1:0] tag_rd, tag_wd;
  logic [SW-1:0]               mul_opd;
  logic [SW+LW-1:0]            prod_wide;

  rasst_ram #(.WIDTH(SW), .DEPTH(NODES)) u_sum_ram (
    .clk(clk), .we(cmd.wr_sum), .waddr(addr), .wdata(sum_wd),
    .raddr(addr), .rdata(sum_rd)
  );

  rasst_ram #(.WIDTH(rasst_pkg::TAG_W), .DEPTH(NODES)) u_tag_ram (
    .clk(clk), .we(cmd.wr_tag), .waddr(addr), .wdata(tag_wd),
    .raddr(addr), .rdata(tag_rd)
  );

  always_comb begin
    if (cmd.clr) begin
      sum_wd = '0;
    end else if (cmd.pull) begin
      sum_wd = left_sum + sum_rd;
    end else begin
      sum_wd = rec_sum;
    end
    if (cmd.clr) begin
      tag_wd = '0;
    end else if (cmd.par_wr) begin
      tag_wd = {1'b0, par_av, {SW{1'b0}}};
    end else begin
      tag_wd = {rec_flag, rec_av, rec_add};
    end
  end

  assign mul_opd   = cmd.mul_val ? src_val : src_add;
  assign prod_wide = mul_opd * len_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      operand <= operand_value;
      acc     <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + sum_rd;
    end
    if (cmd.ld_par) begin
      par_flag <= tag_rd[2*SW];
      par_av   <= tag_rd[2*SW-1:SW];
      par_add  <= tag_rd[SW-1:0];
    end
    if (cmd.ld_src_item) begin
      src_flag <= cmd.item_asg;
      src_val  <= operand;
      src_add  <= cmd.item_add ? operand : '0;
      len_r    <= len;
    end else if (cmd.ld_src_par) begin
      src_flag <= par_flag;
      src_val  <= par_av;
      src_add  <= par_add;
      len_r    <= len;
    end
    if (cmd.mul_val || cmd.mul_add) begin
      prod <= prod_wide[SW-1:0];
    end
    if (cmd.ld_rec) begin
      rec_sum  <= sum_rd;
      rec_flag <= tag_rd[2*SW];
      rec_av   <= tag_rd[2*SW-1:SW];
      rec_add  <= tag_rd[SW-1:0];
    end else if (cmd.app_asg) begin
      if (src_flag) begin
        rec_sum  <= prod;
        rec_add  <= '0;
        rec_av   <= src_val;
        rec_flag <= 1'b1;
      end
    end else if (cmd.app_add) begin
      rec_sum <= rec_sum + prod;
      rec_add <= rec_add + src_add;
    end
    if (cmd.ld_left) begin
      left_sum <= sum_rd;
    end
    if (cmd.ld_out) begin
      range_sum <= acc;
      status    <= cmd.out_bad;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rasst_ctrl.sv =====
// Controller: clearing sweep, walk sequencer with its descent stack, handshakes.
// Uses rasst_pkg; drives rasst_dp through dp_cmd_t.
`default_nettype none
module rasst_ctrl #(
  parameter int MAX_ELEMENTS = rasst_pkg::DEF_MAX_ELEMENTS,
  localparam int IW  = $clog2(MAX_ELEMENTS),
  localparam int LW  = IW + 1,
  localparam int NAW = IW + 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      action,
  input  wire logic [rasst_pkg::RIDX_W-1:0]    range_low,
  input  wire logic [rasst_pkg::RIDX_W-1:0]    range_high,
  input  wire logic                            cfg_wr_en,
  input  wire logic [rasst_pkg::CFG_W-1:0]     cfg_wr_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output rasst_pkg::dp_cmd_t                   cmd,
  output logic      [NAW-1:0]                  addr,
  output logic      [LW-1:0]                   len
);

  localparam int NODES = 4 * MAX_ELEMENTS;
  localparam int STK   = IW + 1;
  localparam int SIW   = $clog2(STK);
  localparam int SPW   = $clog2(STK + 1);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_VISIT  = 5'd2;
  localparam logic [4:0] S_COV_RD = 5'd3;
  localparam logic [4:0] S_COV_LD = 5'd4;
  localparam logic [4:0] S_TA_M1  = 5'd5;
  localparam logic [4:0] S_TA_A1  = 5'd6;
  localparam logic [4:0] S_TA_M2  = 5'd7;
  localparam logic [4:0] S_TA_A2  = 5'd8;
  localparam logic [4:0] S_TA_WR  = 5'd9;
  localparam logic [4:0] S_PD_RDP = 5'd10;
  localparam logic [4:0] S_PD_LDP = 5'd11;
  localparam logic [4:0] S_PD_RDC = 5'd12;
  localparam logic [4:0] S_PD_LDC = 5'd13;
  localparam logic [4:0] S_PD_WRP = 5'd14;
  localparam logic [4:0] S_PU_RDL = 5'd15;
  localparam logic [4:0] S_PU_RDR = 5'd16;
  localparam logic [4:0] S_PU_WR  = 5'd17;
  localparam logic [4:0] S_POP    = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  localparam logic [1:0] PH_ENTER = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;
  localparam logic [1:0] PH_PULL  = 2'd3;

  logic [4:0]                      state;
  logic [NAW-1:0]                  clr_cnt;
  logic [rasst_pkg::CFG_W-1:0]     used_size;
  logic [1:0]                      act;
  logic [rasst_pkg::RIDX_W-1:0]    lo, hi;
  logic                            bad;
  logic                            in_pd, child;
  logic [IW-1:0]                   cur_l, cur_r;
  logic [NAW-1:0]                  cur_i;
  logic [1:0]                      cur_ph;
  logic [SPW-1:0]                  sp;
  logic [IW-1:0]                   stk_l [STK];
  logic [IW-1:0]                   stk_r [STK];
  logic [NAW-1:0]                  stk_i [STK];
  logic [1:0]                      stk_ph [STK];

  logic [LW-1:0]  n_eff, mid_w, left_len, right_len, cov_len;
  logic [IW-1:0]  mid;
  logic           covered, go_left, go_right, item_bad;
  logic [NAW-1:0] left_i, right_i;
  logic [SIW-1:0] top;

  always_comb begin
    if (32'(used_size) > MAX_ELEMENTS) begin
      n_eff = LW'(MAX_ELEMENTS);
    end else begin
      n_eff = LW'(used_size);
    end
  end

  assign item_bad = (action == rasst_pkg::ACT_RSVD) || (n_eff == '0) ||
                    (range_low > range_high) || (32'(range_high) >= 32'(n_eff));
  assign mid_w     = (LW'(cur_l) + LW'(cur_r)) >> 1;
  assign mid       = mid_w[IW-1:0];
  assign left_len  = mid_w - LW'(cur_l) + LW'(1);
  assign right_len = LW'(cur_r) - mid_w;
  assign cov_len   = LW'(cur_r) - LW'(cur_l) + LW'(1);
  assign covered   = (32'(lo) <= 32'(cur_l)) && (32'(cur_r) <= 32'(hi));
  assign go_left   = 32'(lo) <= 32'(mid);
  assign go_right  = 32'(hi) > 32'(mid);
  assign left_i    = {cur_i[NAW-2:0], 1'b0};
  assign right_i   = {cur_i[NAW-2:0], 1'b1};
  assign top       = SIW'(sp - SPW'(1));
  assign in_stall  = (state != S_IDLE);

  // Address and command decode.
  always_comb begin
    cmd  = '0;
    addr = cur_i;
    len  = cov_len;
    unique case (state)
      S_CLEAR: begin
        addr = clr_cnt;
        cmd.clr = 1'b1;
        cmd.wr_sum = 1'b1;
        cmd.wr_tag = 1'b1;
      end
      S_IDLE:   cmd.ld_item = in_valid;
      S_COV_LD: begin
        if (act == rasst_pkg::ACT_QUERY) begin
          cmd.acc_add = 1'b1;
        end else begin
          cmd.ld_rec = 1'b1;
          cmd.ld_src_item = 1'b1;
          cmd.item_asg = (act == rasst_pkg::ACT_ASSIGN);
          cmd.item_add = (act == rasst_pkg::ACT_ADD);
        end
      end
      S_TA_M1:  cmd.mul_val = 1'b1;
      S_TA_A1:  cmd.app_asg = 1'b1;
      S_TA_M2:  cmd.mul_add = 1'b1;
      S_TA_A2:  cmd.app_add = 1'b1;
      S_TA_WR: begin
        addr = in_pd ? (child ? right_i : left_i) : cur_i;
        cmd.wr_sum = 1'b1;
        cmd.wr_tag = 1'b1;
      end
      S_PD_LDP: cmd.ld_par = 1'b1;
      S_PD_RDC: addr = child ? right_i : left_i;
      S_PD_LDC: begin
        addr = child ? right_i : left_i;
        len = child ? right_len : left_len;
        cmd.ld_rec = 1'b1;
        cmd.ld_src_par = 1'b1;
      end
      S_PD_WRP: begin
        cmd.wr_tag = 1'b1;
        cmd.par_wr = 1'b1;
      end
      S_PU_RDL: addr = left_i;
      S_PU_RDR: begin
        addr = right_i;
        cmd.ld_left = 1'b1;
      end
      S_PU_WR: begin
        cmd.wr_sum = 1'b1;
        cmd.pull = 1'b1;
      end
      S_DONE: begin
        cmd.ld_out = !out_valid || !out_stall;
        cmd.out_bad = bad;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      used_size <= rasst_pkg::USED_SIZE_RST;
      out_valid <= 1'b0;
      sp        <= '0;
      in_pd     <= 1'b0;
      child     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        used_size <= cfg_wr_data;
      end
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + NAW'(1);
          if (clr_cnt == NAW'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act   <= action;
            lo    <= range_low;
            hi    <= range_high;
            bad   <= item_bad;
            sp    <= '0;
            cur_l <= '0;
            cur_r <= IW'(n_eff - LW'(1));
            cur_i <= NAW'(1);
            cur_ph <= PH_ENTER;
            state <= item_bad ? S_DONE : S_VISIT;
          end
        end
        S_VISIT: begin
          unique case (cur_ph)
            PH_ENTER: state <= covered ? S_COV_RD : S_PD_RDP;
            PH_LEFT: begin
              if (go_left) begin
                stk_l[sp[SIW-1:0]]  <= cur_l;
                stk_r[sp[SIW-1:0]]  <= cur_r;
                stk_i[sp[SIW-1:0]]  <= cur_i;
                stk_ph[sp[SIW-1:0]] <= PH_RIGHT;
                sp     <= sp + SPW'(1);
                cur_r  <= mid;
                cur_i  <= left_i;
                cur_ph <= PH_ENTER;
              end else begin
                cur_ph <= PH_RIGHT;
              end
            end
            PH_RIGHT: begin
              if (go_right) begin
                stk_l[sp[SIW-1:0]]  <= cur_l;
                stk_r[sp[SIW-1:0]]  <= cur_r;
                stk_i[sp[SIW-1:0]]  <= cur_i;
                stk_ph[sp[SIW-1:0]] <= PH_PULL;
                sp     <= sp + SPW'(1);
                cur_l  <= mid + IW'(1);
                cur_i  <= right_i;
                cur_ph <= PH_ENTER;
              end else begin
                cur_ph <= PH_PULL;
              end
            end
            PH_PULL: state <= (act == rasst_pkg::ACT_QUERY) ? S_POP : S_PU_RDL;
            default: ;
          endcase
        end
        S_COV_RD: state <= S_COV_LD;
        S_COV_LD: begin
          in_pd <= 1'b0;
          state <= (act == rasst_pkg::ACT_QUERY) ? S_POP : S_TA_M1;
        end
        S_TA_M1: state <= S_TA_A1;
        S_TA_A1: state <= S_TA_M2;
        S_TA_M2: state <= S_TA_A2;
        S_TA_A2: state <= S_TA_WR;
        S_TA_WR: begin
          if (!in_pd) begin
            state <= S_POP;
          end else if (!child) begin
            child <= 1'b1;
            state <= S_PD_RDC;
          end else begin
            state <= S_PD_WRP;
          end
        end
        S_PD_RDP: state <= S_PD_LDP;
        S_PD_LDP: begin
          in_pd <= 1'b1;
          child <= 1'b0;
          state <= S_PD_RDC;
        end
        S_PD_RDC: state <= S_PD_LDC;
        S_PD_LDC: state <= S_TA_M1;
        S_PD_WRP: begin
          in_pd  <= 1'b0;
          cur_ph <= PH_LEFT;
          state  <= S_VISIT;
        end
        S_PU_RDL: state <= S_PU_RDR;
        S_PU_RDR: state <= S_PU_WR;
        S_PU_WR:  state <= S_POP;
        S_POP: begin
          if (sp == '0) begin
            state <= S_DONE;
          end else begin
            cur_l  <= stk_l[top];
            cur_r  <= stk_r[top];
            cur_i  <= stk_i[top];
            cur_ph <= stk_ph[top];
            sp     <= sp - SPW'(1);
            state  <= S_VISIT;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sp) <= STK) else $error("walk stack overflow");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall) else $error("item taken during clearing sweep");

  a_no_root_zero_write: assert property (@(posedge clk) disable iff (rst)
    ((cmd.wr_sum || cmd.wr_tag) && !cmd.clr) |-> (addr != '0))
    else $error("walk wrote node zero");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |=> out_valid) else $error("result load without valid");

endmodule
`default_nettype wire
